// ----- hdl/wbps_pkg.sv -----
package wbps_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF  = 10;

  localparam int unsigned OFFSET_W    = 32;
  localparam int unsigned TOTAL_W     = 10;
  localparam int unsigned PAT_BYTES   = 16;
  localparam int unsigned PAT_IDX_W   = 4;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned MAX_W       = 10;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 6;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  localparam logic [LEN_W-1:0] LEN_RST      = 5'd1;
  localparam logic [7:0]       WILDCARD_RST = 8'hFF;
  localparam logic [MAX_W-1:0] MAX_RST      = 10'd10;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_WILDCARD     = 3'd3,
    REG_MAX_MATCHES  = 3'd4
  } reg_idx_e;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    kind_e               result_kind;
    logic [OFFSET_W-1:0] match_offset;
    logic [TOTAL_W-1:0]  match_total;
    logic                final_result;
  } res_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- hdl/wbps_stream_if.sv -----
interface wbps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/wbps_cell.sv -----
module wbps_cell import wbps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_i,
  input  logic [7:0] wild_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= ctrl_i.clear ? 8'd0 : byte_i;
    end
  end

  // compare against the value this cell takes on the shift
  assign match_o = !active_i || (pat_i == wild_i) || (byte_i == pat_i);
  assign byte_o  = byte_q;

endmodule

// ----- hdl/wbps_res_queue.sv -----
module wbps_res_queue import wbps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  push_cnt_i,
  input  res_t        data0_i,
  input  res_t        data1_i,
  output logic        space_o,
  wbps_stream_if.source res_o
);

  res_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;
  logic                   pop;

  assign pop = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + QUEUE_PTR_W'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(push_cnt_i);
      rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(pop);
      cnt_q    <= cnt_q + QUEUE_CNT_W'(push_cnt_i) - QUEUE_CNT_W'(pop);
    end
  end

  // room for the two results one request can cause
  assign space_o       = cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
  assign res_o.valid   = cnt_q != '0;
  assign res_o.payload = mem_q[rd_ptr_q];

endmodule

// ----- hdl/wildcard_byte_pattern_scanner.sv -----
// results: each result is written into the result queue as its request is accepted
// throughput: one request per cycle while the result queue has room for two results; a request
//   that causes a match and a summary yields two results, buffered in a four-entry result queue
// the window compare is one pass over the row of cells in the accept cycle
// reset: window, byte and match counters clear; registers take their reset values
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  wbps_stream_if.sink           req_i,
  wbps_stream_if.source         res_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W;
  localparam int unsigned OFF_EXT_W = (OFFSET_BITS > OFFSET_W) ? OFFSET_BITS : OFFSET_W;

  logic [63:0]      pat_low_q, pat_high_q;
  logic [LEN_W-1:0] pat_len_q;
  logic [7:0]       wild_q;
  logic [MAX_W-1:0] max_q;
  logic             wr_en;
  reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= LEN_RST;
      wild_q     <= WILDCARD_RST;
      max_q      <= MAX_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_LOW:  pat_low_q  <= pwdata;
        REG_PATTERN_HIGH: pat_high_q <= pwdata;
        REG_PATTERN_LEN:  pat_len_q  <= pwdata[LEN_W-1:0];
        REG_WILDCARD:     wild_q     <= pwdata[7:0];
        REG_MAX_MATCHES:  max_q      <= pwdata[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PATTERN_LOW:  prdata = pat_low_q;
      REG_PATTERN_HIGH: prdata = pat_high_q;
      REG_PATTERN_LEN:  prdata = CFG_DATA_W'(pat_len_q);
      REG_WILDCARD:     prdata = CFG_DATA_W'(wild_q);
      REG_MAX_MATCHES:  prdata = CFG_DATA_W'(max_q);
      default:          prdata = '0;
    endcase
  end

  // pattern bytes and used length
  logic [8*PAT_BYTES-1:0] pat_all;
  logic [7:0]             pat_bytes [PAT_BYTES];
  logic [LEN_W-1:0]       len_u, len_m1;

  assign pat_all = {pat_high_q, pat_low_q};

  for (genvar i = 0; i < PAT_BYTES; i++) begin : g_pat
    assign pat_bytes[i] = pat_all[8*i +: 8];
  end

  always_comb begin
    len_u = pat_len_q;
    if (len_u == '0) begin
      len_u = LEN_W'(1);
    end else if (len_u > LEN_W'(PATTERN_MAX)) begin
      len_u = LEN_W'(PATTERN_MAX);
    end
  end

  assign len_m1 = len_u - LEN_W'(1);

  // request side
  logic                   accept, last;
  logic                   space;
  cell_ctrl_t             cell_ctrl;
  logic [7:0]             win   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;

  assign accept       = req_i.valid && req_i.ready;
  assign last         = req_i.payload.last_byte;
  assign req_i.ready  = space;
  assign cell_ctrl    = '{shift: accept, clear: last};

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0]       byte_in;
    logic [LEN_W-1:0] pidx_full;
    logic             active;

    if (k == 0) begin : g_head
      assign byte_in = req_i.payload.data_byte;
    end else begin : g_link
      assign byte_in = win[k-1];
    end

    assign active    = LEN_W'(k) <= len_m1;
    assign pidx_full = len_m1 - LEN_W'(k);

    wbps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .byte_i   (byte_in),
      .pat_i    (pat_bytes[pidx_full[PAT_IDX_W-1:0]]),
      .wild_i   (wild_q),
      .active_i (active),
      .byte_o   (win[k]),
      .match_o  (eq[k])
    );
  end

  // counters
  logic [OFFSET_BITS-1:0] seen_q, seen_d, count_after, offset_full;
  logic [COUNT_BITS-1:0]  found_q, found_d, found_inc, found_new;
  logic [CMP_W-1:0]       found_ext, max_ext, total_ext;
  logic [OFF_EXT_W-1:0]   offset_ext;
  logic                   hit, report;

  assign count_after = (seen_q != '1) ? seen_q + OFFSET_BITS'(1) : seen_q;
  assign hit         = (count_after >= OFFSET_BITS'(len_u)) && (&eq);
  assign found_ext   = CMP_W'(found_q);
  assign max_ext     = CMP_W'(max_q);
  assign report      = hit && (found_ext < max_ext);
  assign found_inc   = (found_q != '1) ? found_q + COUNT_BITS'(1) : found_q;
  assign found_new   = report ? found_inc : found_q;
  assign offset_full = seen_q - OFFSET_BITS'(len_m1);
  assign offset_ext  = OFF_EXT_W'(offset_full);
  assign total_ext   = CMP_W'(found_new);

  assign seen_d  = last ? '0 : count_after;
  assign found_d = last ? '0 : found_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      found_q <= '0;
    end else if (accept) begin
      seen_q  <= seen_d;
      found_q <= found_d;
    end
  end

  // results
  res_t       match_res, sum_res, data0;
  logic [1:0] push_cnt;

  assign match_res = '{result_kind:  KIND_MATCH,
                       match_offset: offset_ext[OFFSET_W-1:0],
                       match_total:  total_ext[TOTAL_W-1:0],
                       final_result: !last};
  assign sum_res   = '{result_kind:  KIND_SUMMARY,
                       match_offset: '0,
                       match_total:  total_ext[TOTAL_W-1:0],
                       final_result: 1'b1};
  assign data0     = report ? match_res : sum_res;
  assign push_cnt  = accept ? (2'(report) + 2'(last)) : 2'd0;

  wbps_res_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .data0_i    (data0),
    .data1_i    (sum_res),
    .space_o    (space),
    .res_o      (res_o)
  );

endmodule

// ----- tb/sv/tb_wildcard_byte_pattern_scanner.sv -----
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scanner import wbps_pkg::*;;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_BYTES  = 32;
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  wbps_stream_if #(.payload_t(req_t)) req_bus ();
  wbps_stream_if #(.payload_t(res_t)) res_bus ();

  logic req_valid   = 1'b0;
  req_t req_payload = '0;
  logic res_ready   = 1'b0;
  logic req_fire    = 1'b0;

  assign req_bus.valid   = req_valid;
  assign req_bus.payload = req_payload;
  assign res_bus.ready   = res_ready;

  wildcard_byte_pattern_scanner i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_bus),
    .res_o   (res_bus)
  );

  // register shadows and scan state
  logic [127:0]        pattern_cfg  = '0;
  logic [LEN_W-1:0]    len_cfg      = LEN_RST;
  logic [7:0]          wildcard_cfg = WILDCARD_RST;
  logic [MAX_W-1:0]    max_cfg      = MAX_RST;
  logic [7:0]          window [PAT_BYTES];
  logic [OFFSET_W-1:0] seen_cnt     = '0;
  logic [TOTAL_W-1:0]  found_cnt    = '0;

  req_t pending_bytes [$];
  res_t expected_reports [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned mismatches     = 0;
  int unsigned queued_bytes   = 0;

  initial begin
    for (int i = 0; i < PAT_BYTES; i++) window[i] = 8'h00;
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_len();
    if (len_cfg == 0) return 1;
    if (len_cfg > PAT_BYTES) return PAT_BYTES;
    return len_cfg;
  endfunction

  task automatic scan_byte(input req_t r);
    int unsigned len;
    int unsigned i;
    logic [OFFSET_W-1:0] here;
    logic [7:0] pb;
    logic hit;
    res_t rep;
    len  = eff_len();
    here = seen_cnt;
    for (i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = r.data_byte;
    if (seen_cnt != '1) seen_cnt = seen_cnt + 1'b1;
    hit = (seen_cnt >= len);
    for (i = 0; i < len; i++) begin
      pb = pattern_cfg[8*i +: 8];
      if (pb != wildcard_cfg && window[len-1-i] != pb) hit = 1'b0;
    end
    if (hit && found_cnt < max_cfg) begin
      if (found_cnt != '1) found_cnt = found_cnt + 1'b1;
      rep.result_kind  = KIND_MATCH;
      rep.match_offset = here - OFFSET_W'(len - 1);
      rep.match_total  = found_cnt;
      rep.final_result = !r.last_byte;
      expected_reports.push_back(rep);
    end
    if (r.last_byte) begin
      rep.result_kind  = KIND_SUMMARY;
      rep.match_offset = '0;
      rep.match_total  = found_cnt;
      rep.final_result = 1'b1;
      expected_reports.push_back(rep);
      for (i = 0; i < PAT_BYTES; i++) window[i] = 8'h00;
      seen_cnt  = '0;
      found_cnt = '0;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    res_t want;
    res_t got;
    req_fire <= req_bus.valid && req_bus.ready;
    if (rst_ni && req_bus.valid && req_bus.ready) scan_byte(req_bus.payload);
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got = res_bus.payload;
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected report: expected none actual %p", $time, got);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (got.result_kind !== want.result_kind) begin
          $display("%0t result_kind: expected %0d actual %0d", $time,
                   want.result_kind, got.result_kind);
          mismatches++;
        end
        if (got.match_offset !== want.match_offset) begin
          $display("%0t match_offset: expected %0d actual %0d", $time,
                   want.match_offset, got.match_offset);
          mismatches++;
        end
        if (got.match_total !== want.match_total) begin
          $display("%0t match_total: expected %0d actual %0d", $time,
                   want.match_total, got.match_total);
          mismatches++;
        end
        if (got.final_result !== want.final_result) begin
          $display("%0t final_result: expected %0d actual %0d", $time,
                   want.final_result, got.final_result);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!req_valid || req_fire)) begin
      if (pending_bytes.size() != 0 &&
          !(send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)) begin
        req_payload <= pending_bytes.pop_front();
        req_valid   <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // long hold-off lets the result queue fill and back up the request side
  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      res_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= !(recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_PATTERN_LOW:  pattern_cfg[63:0]   = value;
      REG_PATTERN_HIGH: pattern_cfg[127:64] = value;
      REG_PATTERN_LEN:  len_cfg             = value[LEN_W-1:0];
      REG_WILDCARD:     wildcard_cfg        = value[7:0];
      REG_MAX_MATCHES:  max_cfg             = value[MAX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || req_valid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic last);
    req_t r;
    r.data_byte = data;
    r.last_byte = last;
    pending_bytes.push_back(r);
    queued_bytes++;
  endtask

  // pattern copies with random wildcard content, near misses and noise
  task automatic queue_stream(input int unsigned n);
    logic [7:0] bytes [$];
    logic [7:0] b;
    int unsigned len;
    int unsigned j;
    int unsigned k;
    bit broken;
    len = eff_len();
    while (bytes.size() < n) begin
      if ($urandom_range(0, 2) == 0) begin
        broken = ($urandom_range(0, 3) == 0);
        k = $urandom_range(0, len - 1);
        for (j = 0; j < len; j++) begin
          b = pattern_cfg[8*j +: 8];
          if (b == wildcard_cfg) b = 8'($urandom_range(0, 255));
          if (broken && j == k) b = ~b;
          bytes.push_back(b);
        end
      end else if ($urandom_range(0, 1) == 0) begin
        bytes.push_back(pattern_cfg[8*$urandom_range(0, len - 1) +: 8]);
      end else begin
        bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (j = 0; j < bytes.size(); j++) queue_byte(bytes[j], j == bytes.size() - 1);
  endtask

  task automatic random_setup(input int unsigned p);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0] wild;
    logic [LEN_W-1:0] len;
    logic [MAX_W-1:0] mx;
    int unsigned i;
    case (p % 3)
      0: wild = 8'h00;
      1: wild = 8'hFF;
      default: wild = 8'($urandom_range(0, 255));
    endcase
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    for (i = 0; i < 8; i++) begin
      if ($urandom_range(0, 4) == 0) lo[8*i +: 8] = wild;
      if ($urandom_range(0, 4) == 0) hi[8*i +: 8] = wild;
    end
    case (p % 6)
      0: len = 5'd0;
      1: len = 5'd1;
      2: len = 5'd16;
      3: len = 5'd17;
      4: len = 5'd31;
      default: len = LEN_W'($urandom_range(2, 15));
    endcase
    case ((p / 2) % 4)
      0: mx = 10'd0;
      1: mx = 10'd1;
      2: mx = 10'd1023;
      default: mx = MAX_W'($urandom_range(2, 20));
    endcase
    write_reg(REG_WILDCARD, 64'(wild));
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LEN, 64'(len));
    write_reg(REG_MAX_MATCHES, 64'(mx));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setup: single byte 0x00 pattern
    set_idling(0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // wildcard in the middle, short stream, no carry over after clear
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_00CD_FFAB);
    write_reg(REG_PATTERN_LEN, 64'd3);
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'hCD, 1'b0);
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'hCD, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hAB, 1'b1);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'hCD, 1'b1);
    wait_idle();

    // overlapping matches cut off by the limit, then a zero limit
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_AAAA);
    write_reg(REG_PATTERN_LEN, 64'd2);
    write_reg(REG_MAX_MATCHES, 64'd2);
    repeat (3) queue_byte(8'hAA, 1'b0);
    queue_byte(8'hAA, 1'b1);
    wait_idle();
    write_reg(REG_MAX_MATCHES, 64'd0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'hAA, 1'b1);
    wait_idle();

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      set_idling(p % 4);
      random_setup(p);
      queued_bytes = 0;
      while (queued_bytes < PHASE_BYTES) begin
        if ($urandom_range(0, 5) == 0) queue_stream($urandom_range(1, 3));
        else queue_stream($urandom_range(1, 48));
      end
      if (p == 4) hold_requests++;
      wait_idle();
    end

    // every byte matches: match counter runs up to its top value
    set_idling(0);
    write_reg(REG_WILDCARD, 64'hFF);
    write_reg(REG_PATTERN_LOW, '1);
    write_reg(REG_PATTERN_HIGH, '1);
    write_reg(REG_PATTERN_LEN, 64'd1);
    write_reg(REG_MAX_MATCHES, 64'd1023);
    queue_stream(1030);
    wait_idle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
